/* src/tmt_pkg.sv */
// ----------------------------------------------------------------------------
// tmt_pkg: shared types and constants for the text-mode terminal
// Screen geometry, derived widths, cell codes and the command/result beats.
// ----------------------------------------------------------------------------
package tmt_pkg;

	// Screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	// Derived widths
	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W = $clog2(CELL_COUNT);

	// Fixed field widths
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 8;
	localparam int CELL_W   = COLOR_W + CHAR_W;
	localparam int RADDR_W  = 11;
	localparam int OFFSET_W = 11;
	localparam int CMP_W    = ((ADDR_W > RADDR_W) ? ADDR_W : RADDR_W) + 1;

	// Codes
	localparam logic              OP_WRITE     = 1'b0;
	localparam logic              OP_READ      = 1'b1;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

	// Input beat
	typedef struct packed {
		logic               opcode;
		logic [CHAR_W-1:0]  character;
		logic [RADDR_W-1:0] read_address;
		logic               end_of_write;
	} cmd_t;

	// Result beat
	typedef struct packed {
		logic [OFFSET_W-1:0] cursor_offset;
		logic [CELL_W-1:0]   read_value;
		logic                scrolled;
		logic                last;
	} result_t;

	// Cursor move request
	typedef struct packed {
		logic put;
		logic newline;
	} cur_step_t;

	// Cursor status
	typedef struct packed {
		logic [ADDR_W-1:0] offset;
		logic              at_bottom;
	} cur_stat_t;

endpackage

/* src/tmt_screen_ram.sv */
// ----------------------------------------------------------------------------
// tmt_screen_ram: screen cell memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tmt_screen_ram #(
	parameter int DEPTH  = 2000,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* src/tmt_cursor.sv */
// ----------------------------------------------------------------------------
// tmt_cursor: cursor row/column tracking
// Advances on a put, moves down (or holds on the bottom row) on a newline,
// and gives the linear cell offset of the cursor.
// ----------------------------------------------------------------------------
module tmt_cursor (
	input  logic                clk,
	input  logic                arst_n,
	input  tmt_pkg::cur_step_t  step,
	output tmt_pkg::cur_stat_t  stat
);

	logic [tmt_pkg::ROW_W-1:0] row_q;
	logic [tmt_pkg::COL_W-1:0] col_q;
	logic                      last_col;
	logic                      last_row;

	assign last_col = (col_q == tmt_pkg::COL_W'(tmt_pkg::COLUMNS - 1));
	assign last_row = (row_q == tmt_pkg::ROW_W'(tmt_pkg::ROWS - 1));

	// Linear offset: row * COLUMNS + column
	assign stat.offset = tmt_pkg::ADDR_W'(tmt_pkg::ADDR_W'(row_q)
		* tmt_pkg::ADDR_W'(tmt_pkg::COLUMNS)) + tmt_pkg::ADDR_W'(col_q);
	assign stat.at_bottom = last_row;

	// Cursor update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (step.newline) begin
			col_q <= '0;
			if (!last_row) begin
				row_q <= row_q + 1'b1;
			end
		end else if (step.put) begin
			if (last_col) begin
				col_q <= '0;
				// past the bottom the row wraps to the top, no scroll
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

/* src/text_mode_terminal_top.sv */
// ----------------------------------------------------------------------------
// text_mode_terminal_top: character-cell text terminal
// Screen cells in one synchronous RAM; a sequencer clears it after reset and
// scrolls it up on a newline from the bottom row.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------
//   command  | start / busy        | cmd (tmt_pkg::cmd_t)
//   result   | done (1-cycle)      | result (tmt_pkg::result_t)
//   config   | wr_en               | wr_data (text color)
//
// A read, a character write or a newline above the bottom row is taken
// while idle without going busy; its result comes in the following cycle,
// and a new command may be taken every cycle. A newline on the bottom row
// copies the screen up through the single RAM port pair and then fills the
// bottom row with color-only cells, busy all the while. After reset busy
// stays high while the RAM is cleared to blank cells. Results cannot be
// stalled: done marks each for one cycle.
// ----------------------------------------------------------------------------
module text_mode_terminal_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  tmt_pkg::cmd_t      cmd,
	output logic               done,
	output tmt_pkg::result_t   result,
	input  logic               wr_en,
	input  logic [7:0]         wr_data
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_FILL
	} state_t;

	state_t state_q;

	logic [tmt_pkg::COLOR_W-1:0] color_q;
	logic [tmt_pkg::ADDR_W-1:0]  src_q;
	logic [tmt_pkg::ADDR_W-1:0]  fill_q;
	logic [tmt_pkg::ADDR_W-1:0]  dst_s1;
	logic                        copy_wr_s1;
	logic                        done_q;
	logic                        scrolled_q;
	logic                        rd_hit_q;
	logic                        last_q;

	logic                        accept;
	logic                        is_read;
	logic                        is_newline;
	logic                        is_put;
	logic                        rd_in_range;
	logic                        fill_last;
	logic                        fill_go;

	tmt_pkg::cur_step_t          step;
	tmt_pkg::cur_stat_t          cur;

	logic                        ram_we;
	logic [tmt_pkg::ADDR_W-1:0]  ram_waddr;
	logic [tmt_pkg::CELL_W-1:0]  ram_wdata;
	logic [tmt_pkg::ADDR_W-1:0]  ram_raddr;
	logic [tmt_pkg::CELL_W-1:0]  ram_q;

	// Command decode
	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign is_read     = (cmd.opcode == tmt_pkg::OP_READ);
	assign is_newline  = !is_read && (cmd.character == tmt_pkg::NEWLINE_CHAR);
	assign is_put      = !is_read && !is_newline;
	assign rd_in_range = (tmt_pkg::CMP_W'(cmd.read_address)
		< tmt_pkg::CMP_W'(tmt_pkg::CELL_COUNT));

	assign step.put     = accept && is_put;
	assign step.newline = accept && is_newline;

	// Fill/clear writes wait while the last copy beat drains
	assign fill_go   = ((state_q == ST_FILL) || (state_q == ST_CLEAR)) && !copy_wr_s1;
	assign fill_last = fill_go && (fill_q == tmt_pkg::ADDR_W'(tmt_pkg::CELL_COUNT - 1));

	tmt_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.stat   (cur)
	);

	// Write port: copy beat, then fill/clear, then a character put
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cur.offset;
		ram_wdata = {color_q, cmd.character};
		if (copy_wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = dst_s1;
			ram_wdata = ram_q;
		end else if (fill_go) begin
			ram_we    = 1'b1;
			ram_waddr = fill_q;
			ram_wdata = (state_q == ST_CLEAR) ? tmt_pkg::BLANK_CELL
				: {color_q, {tmt_pkg::CHAR_W{1'b0}}};
		end else if (step.put) begin
			ram_we = 1'b1;
		end
	end

	// Read port: copy source while scrolling, else the command address
	assign ram_raddr = (state_q == ST_COPY) ? src_q
		: tmt_pkg::ADDR_W'(cmd.read_address);

	tmt_screen_ram #(
		.DEPTH  (tmt_pkg::CELL_COUNT),
		.WIDTH  (tmt_pkg::CELL_W),
		.ADDR_W (tmt_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_q)
	);

	// Color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tmt_pkg::RESET_COLOR;
		end else if (wr_en) begin
			color_q <= wr_data;
		end
	end

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			src_q      <= '0;
			fill_q     <= '0;
			dst_s1     <= '0;
			copy_wr_s1 <= 1'b0;
			done_q     <= 1'b0;
			scrolled_q <= 1'b0;
			rd_hit_q   <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			scrolled_q <= 1'b0;
			copy_wr_s1 <= (state_q == ST_COPY);
			dst_s1     <= src_q - tmt_pkg::ADDR_W'(tmt_pkg::COLUMNS);
			if (fill_go) begin
				fill_q <= fill_q + 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					if (fill_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						last_q   <= cmd.end_of_write;
						rd_hit_q <= is_read && rd_in_range;
						if (is_newline && cur.at_bottom) begin
							state_q <= ST_COPY;
							src_q   <= tmt_pkg::ADDR_W'(tmt_pkg::COLUMNS);
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_COPY: begin
					src_q <= src_q + 1'b1;
					if (src_q == tmt_pkg::ADDR_W'(tmt_pkg::CELL_COUNT - 1)) begin
						state_q <= ST_FILL;
						fill_q  <= tmt_pkg::ADDR_W'(tmt_pkg::CELL_COUNT - tmt_pkg::COLUMNS);
					end
				end
				ST_FILL: begin
					if (fill_last) begin
						state_q    <= ST_IDLE;
						done_q     <= 1'b1;
						scrolled_q <= 1'b1;
						rd_hit_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result beat
	assign done                 = done_q;
	assign result.cursor_offset = tmt_pkg::OFFSET_W'(cur.offset);
	assign result.read_value    = rd_hit_q ? ram_q : '0;
	assign result.scrolled      = scrolled_q;
	assign result.last          = last_q;

endmodule

/* tb/sv/tb_text_mode_terminal_top.sv */
// ----------------------------------------------------------------------------
// tb_text_mode_terminal_top: self-checking bench for the text-mode terminal
// A clocked driver feeds command beats and color writes from a planned queue,
// with random gaps between commands. A clocked monitor keeps a shadow screen,
// cursor and color, and predicts each result when its command is taken.
// Every done beat is checked field by field against the oldest prediction.
// Color writes go in only while the terminal is idle with nothing awaited.
// ----------------------------------------------------------------------------
module tb_text_mode_terminal_top;
	import tmt_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 6;
	localparam int QUIET_CYCLES   = 4;          // idle cycles ahead of a color write
	localparam int DRAIN_CYCLES   = 20;
	localparam int CYCLE_LIMIT    = 2_500_000;
	localparam int NEWLINE_BUDGET = 160;        // bounds the number of scrolls
	localparam int PHASE_BEATS    = 190;
	localparam int PHASE_COUNT    = 8;

	// One planned entry: a command beat or a color write
	typedef struct {
		logic         is_color;
		cmd_t         beat;
		logic [7:0]   color;
		int           gap;
	} stim_t;

	logic       clk     = 1'b0;
	logic       arst_n  = 1'b0;
	logic       start   = 1'b0;
	cmd_t       cmd     = '0;
	logic       wr_en   = 1'b0;
	logic [7:0] wr_data = '0;
	logic       busy;
	logic       done;
	result_t    result;

	stim_t   stim_queue[$];
	result_t awaited_beats[$];
	logic    beat_taken = 1'b0;
	int      gap_left   = 0;
	int      quiet_run  = 0;
	int      mismatches = 0;
	int      beats_seen = 0;
	int      newlines_left = NEWLINE_BUDGET;

	// Shadow terminal state
	logic [CELL_W-1:0]  shadow_cells [0:CELL_COUNT-1];
	int                 shadow_row;
	int                 shadow_col;
	logic [COLOR_W-1:0] shadow_color;

	text_mode_terminal_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Applies one command to the shadow terminal and returns its result beat
	function automatic result_t advance_terminal(cmd_t c);
		result_t r;
		int      i;
		r = '0;
		r.last = c.end_of_write;
		if (c.opcode == OP_READ) begin
			if (int'(c.read_address) < CELL_COUNT)
				r.read_value = shadow_cells[c.read_address];
		end else if (c.character == NEWLINE_CHAR) begin
			if (shadow_row + 1 >= ROWS) begin
				// scroll up, bottom row becomes color-only cells
				for (i = 0; i + COLUMNS < CELL_COUNT; i++)
					shadow_cells[i] = shadow_cells[i + COLUMNS];
				for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
					shadow_cells[i] = {shadow_color, 8'h00};
				shadow_row = ROWS - 1;
				r.scrolled = 1'b1;
			end else begin
				shadow_row++;
			end
			shadow_col = 0;
		end else begin
			shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, c.character};
			shadow_col++;
			if (shadow_col >= COLUMNS) begin
				// wrap to next line, bottom wraps to top without scrolling
				shadow_col = 0;
				shadow_row++;
				if (shadow_row >= ROWS)
					shadow_row = 0;
			end
		end
		r.cursor_offset = OFFSET_W'(shadow_row * COLUMNS + shadow_col);
		return r;
	endfunction

	task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("beat %0d %s: expected 'h%0h, got 'h%0h", beats_seen, what, want, got);
	endtask

	// Monitor: checks done beats, tracks color writes, predicts taken commands
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			beat_taken <= 1'b0;
			for (int i = 0; i < CELL_COUNT; i++)
				shadow_cells[i] = BLANK_CELL;
			shadow_row   = 0;
			shadow_col   = 0;
			shadow_color = RESET_COLOR;
		end else begin
			beat_taken <= start && !busy;
			if (wr_en)
				shadow_color = wr_data;
			if (done) begin
				if (awaited_beats.size() == 0) begin
					note_mismatch("result with nothing awaited", '0, 32'(result));
				end else begin
					want = awaited_beats.pop_front();
					if (result.cursor_offset !== want.cursor_offset)
						note_mismatch("cursor_offset", 32'(want.cursor_offset),
							32'(result.cursor_offset));
					if (result.read_value !== want.read_value)
						note_mismatch("read_value", 32'(want.read_value), 32'(result.read_value));
					if (result.scrolled !== want.scrolled)
						note_mismatch("scrolled", 32'(want.scrolled), 32'(result.scrolled));
					if (result.last !== want.last)
						note_mismatch("last", 32'(want.last), 32'(result.last));
				end
				beats_seen++;
			end
			if (start && !busy)
				awaited_beats.push_back(advance_terminal(cmd));
		end
	end

	// Driver: holds start until taken; color writes wait for a quiet terminal
	always @(negedge clk) begin
		logic       nxt_start;
		cmd_t       nxt_cmd;
		logic       nxt_wr;
		logic [7:0] nxt_data;
		if (arst_n) begin
			nxt_start = start && !beat_taken;
			nxt_cmd   = cmd;
			nxt_wr    = 1'b0;
			nxt_data  = wr_data;
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (stim_queue.size() > 0) begin
					if (stim_queue[0].is_color) begin
						if (awaited_beats.size() == 0 && !busy && !start)
							quiet_run++;
						else
							quiet_run = 0;
						if (quiet_run >= QUIET_CYCLES) begin
							nxt_wr    = 1'b1;
							nxt_data  = stim_queue[0].color;
							quiet_run = 0;
							void'(stim_queue.pop_front());
						end
					end else begin
						nxt_start = 1'b1;
						nxt_cmd   = stim_queue[0].beat;
						gap_left  = stim_queue[0].gap;
						void'(stim_queue.pop_front());
					end
				end
			end
			start   <= nxt_start;
			cmd     <= nxt_cmd;
			wr_en   <= nxt_wr;
			wr_data <= nxt_data;
		end
	end

	// Written byte: newline with the given odds while the budget lasts
	function automatic logic [7:0] pick_char(int nl_pct);
		logic [7:0] ch;
		if ($urandom_range(0, 99) < nl_pct && newlines_left > 0) begin
			newlines_left--;
			return NEWLINE_CHAR;
		end
		do ch = 8'($urandom_range(0, 255)); while (ch == NEWLINE_CHAR);
		return ch;
	endfunction

	// Idle cycles after a beat: mostly none or short, a few long
	function automatic int pick_gap(bit idling);
		int r;
		if (!idling)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(12, 60);
	endfunction

	// Read address: top rows, bottom row, anywhere, or past the screen
	function automatic logic [RADDR_W-1:0] pick_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return RADDR_W'($urandom_range(0, 2 * COLUMNS - 1));
		if (r < 50)
			return RADDR_W'($urandom_range(CELL_COUNT - COLUMNS, CELL_COUNT - 1));
		if (r < 90)
			return RADDR_W'($urandom_range(0, CELL_COUNT - 1));
		return RADDR_W'($urandom_range(CELL_COUNT, (1 << RADDR_W) - 1));
	endfunction

	task automatic queue_beat(logic op, logic [7:0] ch, logic [RADDR_W-1:0] addr, logic eow,
		int gap);
		stim_t s;
		s.is_color = 1'b0;
		s.beat.opcode = op;
		s.beat.character = ch;
		s.beat.read_address = addr;
		s.beat.end_of_write = eow;
		s.color = '0;
		s.gap = gap;
		stim_queue.push_back(s);
	endtask

	task automatic queue_color(logic [7:0] c);
		stim_t s;
		s.is_color = 1'b1;
		s.beat = '0;
		s.color = c;
		s.gap = 0;
		stim_queue.push_back(s);
	endtask

	initial begin
		logic [7:0] phase_colors [PHASE_COUNT];
		int         planned;
		int         len;
		int         kind;
		bit         idling;
		logic       op;

		// Directed: reads at the edges, byte extremes, newline, read ignores byte
		queue_beat(OP_READ, 8'h00, 0, 1'b0, 0);
		queue_beat(OP_READ, 8'hFF, RADDR_W'(CELL_COUNT - 1), 1'b1, 0);
		queue_beat(OP_READ, 8'h00, RADDR_W'(CELL_COUNT), 1'b0, 0);
		queue_beat(OP_READ, 8'h00, '1, 1'b1, 0);
		queue_beat(OP_READ, 8'h00, 11'h400, 1'b0, 2);
		queue_beat(OP_WRITE, 8'h41, 0, 1'b0, 0);
		queue_beat(OP_WRITE, 8'h00, 0, 1'b0, 0);
		queue_beat(OP_WRITE, 8'hFF, '1, 1'b1, 0);
		queue_beat(OP_READ, 8'h00, 0, 1'b0, 0);
		queue_beat(OP_READ, 8'h00, 1, 1'b0, 0);
		queue_beat(OP_READ, 8'h00, 2, 1'b1, 1);
		queue_beat(OP_WRITE, NEWLINE_CHAR, 0, 1'b1, 0);
		newlines_left--;
		queue_beat(OP_READ, NEWLINE_CHAR, RADDR_W'(COLUMNS), 1'b0, 0);
		queue_beat(OP_WRITE, 8'h78, '1, 1'b1, 0);
		queue_beat(OP_READ, 8'h00, RADDR_W'(COLUMNS), 1'b1, 0);
		queue_beat(OP_READ, 8'h00, RADDR_W'(COLUMNS + 1), 1'b0, 0);

		// Random phases, each opening with a text color write
		phase_colors = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'h1E,
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'hF0, 8'hFF};
		for (int p = 0; p < PHASE_COUNT; p++) begin
			queue_color(phase_colors[p]);
			idling = (p % 3) != 0;
			planned = 0;
			while (planned < PHASE_BEATS) begin
				kind = $urandom_range(0, 99);
				if (kind < 45) begin
					// one write call of short text
					len = $urandom_range(1, 24);
					for (int k = 0; k < len; k++)
						queue_beat(OP_WRITE, pick_char(4), pick_address(), k == len - 1,
							pick_gap(idling));
				end else if (kind < 53) begin
					// line-wrapping text with no newline
					len = $urandom_range(COLUMNS, COLUMNS + 20);
					for (int k = 0; k < len; k++)
						queue_beat(OP_WRITE, pick_char(0), pick_address(), k == len - 1,
							pick_gap(idling));
				end else if (kind < 58) begin
					// run of newlines, each one on the bottom row scrolls
					len = $urandom_range(1, 8);
					for (int k = 0; k < len; k++)
						queue_beat(OP_WRITE, pick_char(100), pick_address(), k == len - 1,
							pick_gap(idling));
				end else if (kind < 90) begin
					len = $urandom_range(1, 6);
					for (int k = 0; k < len; k++)
						queue_beat(OP_READ, 8'($urandom_range(0, 255)), pick_address(),
							1'($urandom_range(0, 1)), pick_gap(idling));
				end else begin
					// single noise beat, any field value
					len = 1;
					op = 1'($urandom_range(0, 1));
					queue_beat(op, (op == OP_READ) ? 8'($urandom_range(0, 255)) : pick_char(10),
						RADDR_W'($urandom_range(0, (1 << RADDR_W) - 1)),
						1'($urandom_range(0, 1)), pick_gap(idling));
				end
				planned += len;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_queue.size() != 0 || start || awaited_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_beats.size() == 0)
			$display("text_mode_terminal_top verification clean");
		else
			$display("text_mode_terminal_top verification failed");
		$finish;
	end

	initial begin
		#(CYCLE_LIMIT * CLK_PERIOD);
		$display("text_mode_terminal_top verification failed");
		$finish;
	end

endmodule

/* text_mode_terminal_top.f */
src/tmt_pkg.sv
src/tmt_screen_ram.sv
src/tmt_cursor.sv
src/text_mode_terminal_top.sv
tb/sv/tb_text_mode_terminal_top.sv
